[hdl/tmap_pkg.sv]
// shared types and constants for the half-float reinhard tonemapper
`default_nettype none
package tmap_pkg;

   localparam int unsigned NUM_CHAN   = 3;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned HALF_W     = 16;
   localparam int unsigned SIG_W      = 11;
   localparam int unsigned PROD_W     = GAIN_W + SIG_W;   // 27
   localparam int unsigned EXP_W      = 5;
   localparam int unsigned X_W        = PROD_W + 5;       // 32
   localparam int unsigned D_W        = 25;               // up to 2^24
   localparam int unsigned NUM_W      = 42;               // 511*X + D
   localparam int unsigned DEN_W      = 34;               // 2*(X + D)
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned DIV_STEPS  = 8;

   localparam logic [EXP_W-1:0]  EXP_SPECIAL = 5'h1F;
   localparam logic [EXP_W-1:0]  EXP_UNITY   = 5'd25;
   localparam logic [BYTE_W-1:0] BYTE_FULL   = 8'hFF;

   // csr register byte addresses
   localparam logic [2:0] CSR_ADDR_GAIN = 3'd0;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd400;

   // one channel after decode
   typedef struct packed {
      logic              sat;    // positive infinity
      logic [EXP_W-1:0]  expo;   // effective biased exponent (1 for subnormals)
      logic [PROD_W-1:0] prod;   // gain * significand, 0 for forced-zero
   } chan_work_type;

   typedef struct packed {
      chan_work_type [NUM_CHAN-1:0] chan;
      logic                         eof;
   } front_item_type;

   typedef struct packed {
      logic [NUM_CHAN-1:0][BYTE_W-1:0] bytes;
      logic                            eof;
   } back_item_type;

endpackage
`default_nettype wire

[hdl/tmap_fifo.sv]
// small generic register queue with full and empty flags
`default_nettype none
module tmap_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      rd_data
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

[hdl/tmap_front.sv]
// front end: decodes the three half channels and forms gain * significand
`default_nettype none
module tmap_front (
   input  wire logic [tmap_pkg::GAIN_W-1:0] gain,
   input  wire logic [tmap_pkg::HALF_W-1:0] red_half,
   input  wire logic [tmap_pkg::HALF_W-1:0] green_half,
   input  wire logic [tmap_pkg::HALF_W-1:0] blue_half,
   input  wire logic                        end_of_frame,
   output tmap_pkg::front_item_type         item
);
   import tmap_pkg::*;

   logic [HALF_W-1:0] halves [NUM_CHAN];

   assign halves[0] = red_half;
   assign halves[1] = green_half;
   assign halves[2] = blue_half;

   // per-channel classify and scale
   always_comb begin
      logic [EXP_W-1:0]  e;
      logic [9:0]        frac;
      logic [SIG_W-1:0]  sig;
      logic              zero;
      item.eof = end_of_frame;
      for (int c = 0; c < NUM_CHAN; c++) begin
         e    = halves[c][14:10];
         frac = halves[c][9:0];
         sig  = (e == '0) ? {1'b0, frac} : {1'b1, frac};
         // negative, nan, infinity and zero give a zero product to the divider
         zero = halves[c][15] || (e == EXP_SPECIAL) || (e == '0 && frac == '0);
         item.chan[c].sat  = !halves[c][15] && (e == EXP_SPECIAL) && (frac == '0);
         item.chan[c].expo = (e == '0) ? EXP_W'(1) : e;
         item.chan[c].prod = zero ? '0 : PROD_W'(gain) * PROD_W'(sig);
      end
   end

endmodule
`default_nettype wire

[hdl/tmap_back.sv]
// back end: fixed-point reinhard curve with an eight-step pipelined divide
`default_nettype none
module tmap_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire tmap_pkg::front_item_type in_item,
   output logic                          in_pop,
   input  wire logic                     out_full,
   output logic                          out_push,
   output tmap_pkg::back_item_type       out_item
);
   import tmap_pkg::*;

   localparam int unsigned LAST = DIV_STEPS;

   logic advance;

   // stage 1: operands x and d
   logic                v1_ff;
   logic                eof1_ff;
   logic [NUM_CHAN-1:0] sat1_ff;
   logic [X_W-1:0]      x1_ff [NUM_CHAN];
   logic [D_W-1:0]      d1_ff [NUM_CHAN];
   logic [X_W-1:0]      x1_in [NUM_CHAN];
   logic [D_W-1:0]      d1_in [NUM_CHAN];

   // stage 2 and divide steps
   logic [LAST:0]             vp_ff;
   logic [LAST:0]             eofp_ff;
   logic [NUM_CHAN-1:0]       satp_ff [LAST+1];
   logic [NUM_W-1:0]          rem_ff  [LAST+1][NUM_CHAN];
   logic [DEN_W-1:0]          den_ff  [LAST+1][NUM_CHAN];
   logic [BYTE_W-1:0]         quo_ff  [LAST+1][NUM_CHAN];
   logic [NUM_W-1:0]          rem_in  [LAST+1][NUM_CHAN];
   logic [BYTE_W-1:0]         quo_in  [LAST+1][NUM_CHAN];
   logic [NUM_W-1:0]          num_in  [NUM_CHAN];
   logic [DEN_W-1:0]          den_in  [NUM_CHAN];

   assign advance  = !out_full;
   assign in_pop   = advance && in_valid;
   assign out_push = advance && vp_ff[LAST];

   // x = p << (e - 25) or p, d = 1 or 2^(25 - e)
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (in_item.chan[c].expo >= EXP_UNITY) begin
            x1_in[c] = {{(X_W-PROD_W){1'b0}}, in_item.chan[c].prod}
                       << (in_item.chan[c].expo - EXP_UNITY);
            d1_in[c] = D_W'(1);
         end else begin
            x1_in[c] = {{(X_W-PROD_W){1'b0}}, in_item.chan[c].prod};
            d1_in[c] = D_W'(1) << (EXP_UNITY - in_item.chan[c].expo);
         end
      end
   end

   // numerator 511x + d and denominator 2(x + d)
   always_comb begin
      logic [X_W:0] sum;
      for (int c = 0; c < NUM_CHAN; c++) begin
         num_in[c] = {1'b0, x1_ff[c], 9'b0} - {{(NUM_W-X_W){1'b0}}, x1_ff[c]}
                     + {{(NUM_W-D_W){1'b0}}, d1_ff[c]};
         sum       = {1'b0, x1_ff[c]} + {{(X_W+1-D_W){1'b0}}, d1_ff[c]};
         den_in[c] = {sum, 1'b0};
      end
   end

   // restoring divide, one quotient bit per stage, msb first
   always_comb begin
      logic [NUM_W-1:0] trial;
      for (int s = 0; s < LAST + 1; s++) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            rem_in[s][c] = rem_ff[s][c];
            quo_in[s][c] = quo_ff[s][c];
         end
      end
      for (int s = 0; s < LAST; s++) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            trial = {{(NUM_W-DEN_W){1'b0}}, den_ff[s][c]} << (DIV_STEPS - 1 - s);
            if (rem_ff[s][c] >= trial) begin
               rem_in[s][c] = rem_ff[s][c] - trial;
               quo_in[s][c] = {quo_ff[s][c][BYTE_W-2:0], 1'b1};
            end else begin
               quo_in[s][c] = {quo_ff[s][c][BYTE_W-2:0], 1'b0};
            end
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         vp_ff <= '0;
      end else if (advance) begin
         v1_ff <= in_valid;
         vp_ff <= {vp_ff[LAST-1:0], v1_ff};
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         eof1_ff <= in_item.eof;
         for (int c = 0; c < NUM_CHAN; c++) begin
            sat1_ff[c]      <= in_item.chan[c].sat;
            x1_ff[c]        <= x1_in[c];
            d1_ff[c]        <= d1_in[c];
            rem_ff[0][c]    <= num_in[c];
            den_ff[0][c]    <= den_in[c];
            quo_ff[0][c]    <= '0;
         end
         eofp_ff[0] <= eof1_ff;
         satp_ff[0] <= sat1_ff;
         for (int s = 1; s < LAST + 1; s++) begin
            eofp_ff[s] <= eofp_ff[s-1];
            satp_ff[s] <= satp_ff[s-1];
            for (int c = 0; c < NUM_CHAN; c++) begin
               rem_ff[s][c] <= rem_in[s-1][c];
               den_ff[s][c] <= den_ff[s-1][c];
               quo_ff[s][c] <= quo_in[s-1][c];
            end
         end
      end
   end

   // result assembly, infinity saturates
   always_comb begin
      out_item.eof = eofp_ff[LAST];
      for (int c = 0; c < NUM_CHAN; c++) begin
         out_item.bytes[c] = satp_ff[LAST][c] ? BYTE_FULL : quo_ff[LAST][c];
      end
   end

endmodule
`default_nettype wire

[hdl/hdr_half_reinhard_tonemap.sv]
// top level of the half-float reinhard tonemapper
//
//   port group | direction | handshake         | payload
//   req_       | in        | push / full       | three binary16 channels, end of frame
//   rsp_       | out       | pop / empty       | rgba bytes, frame done
//   csr_       | in/out    | apb write/read    | exposure gain at byte address 0
//
// one pixel per clock sustained unless rsp stalls; a request reaches rsp via the
// request queue, operand and numerator stages, eight divide steps, output queue.
// the divider pipeline sets the latency: one quotient bit per stage.
// synchronous active-high reset empties both queues and loads gain 400.
// a stalled output holds the divider pipeline; the request queue then absorbs input.
`default_nettype none
module hdr_half_reinhard_tonemap #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [15:0] req_red_half,
   input  wire logic [15:0] req_green_half,
   input  wire logic [15:0] req_blue_half,
   input  wire logic        req_end_of_frame,
   // response channel
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_red_byte,
   output logic [7:0]       rsp_green_byte,
   output logic [7:0]       rsp_blue_byte,
   output logic [7:0]       rsp_alpha_byte,
   output logic             rsp_frame_done,
   // csr port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import tmap_pkg::*;

   localparam int unsigned FRONT_W = $bits(front_item_type);
   localparam int unsigned BACK_W  = $bits(back_item_type);

   logic [GAIN_W-1:0] gain_ff, gain_in;
   front_item_type    front_item, queue_item;
   back_item_type     back_item, rsp_item;
   logic              queue_empty, queue_pop;
   logic              out_full, out_push;

   // csr register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_GAIN) ? {16'b0, gain_ff} : 32'b0;

   always_comb begin
      gain_in = gain_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         gain_in = csr_pwdata[GAIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // decode
   tmap_front u_front (
      .gain         (gain_ff),
      .red_half     (req_red_half),
      .green_half   (req_green_half),
      .blue_half    (req_blue_half),
      .end_of_frame (req_end_of_frame),
      .item         (front_item)
   );

   // queue between decode and curve
   tmap_fifo #(.WIDTH(FRONT_W), .DEPTH(QUEUE_DEPTH)) u_req_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (front_item),
      .full    (req_full),
      .pop     (queue_pop),
      .empty   (queue_empty),
      .rd_data (queue_item)
   );

   // curve and divide
   tmap_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (!queue_empty),
      .in_item  (queue_item),
      .in_pop   (queue_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_item (back_item)
   );

   // output queue
   tmap_fifo #(.WIDTH(BACK_W), .DEPTH(2)) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (back_item),
      .full    (out_full),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_item)
   );

   assign rsp_red_byte   = rsp_item.bytes[0];
   assign rsp_green_byte = rsp_item.bytes[1];
   assign rsp_blue_byte  = rsp_item.bytes[2];
   assign rsp_alpha_byte = BYTE_FULL;
   assign rsp_frame_done = rsp_item.eof;

endmodule
`default_nettype wire
